// File: src/go_to_goal_velocity_command_unit_macros.svh
// Assertion macros for the go-to-goal velocity command unit.
// Used by the top level only; expects signals clk and rst in scope.
`ifndef GO_TO_GOAL_VELOCITY_COMMAND_UNIT_MACROS_SVH
`define GO_TO_GOAL_VELOCITY_COMMAND_UNIT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define GTG_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// An implication checked in the same cycle.
`define GTG_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: src/gtg_pkg.sv
// Shared types, constants and tables of the go-to-goal velocity command unit.
// No dependencies; every file of the block but the macro header imports it.
package gtg_pkg;

  localparam int CORDIC_STAGES   = 16;
  localparam int ANGLE_FRAC_BITS = 13;

  localparam int ACC_FRAC   = 30;
  localparam int GUARD_BITS = 8;
  localparam int MAX_TABLE  = 24;
  localparam int STAGE_W    = 5;

  // Datapath widths: x/y carry the offset with guard bits plus CORDIC growth,
  // z carries the angle with 30 fraction bits plus the pre-rotation by pi.
  localparam int DW = 33;
  localparam int XW = DW + GUARD_BITS + 3;
  localparam int ZW = 35;

  localparam int ASHIFT = ACC_FRAC - ANGLE_FRAC_BITS;
  localparam int BW     = ZW - ASHIFT + 1;
  localparam int EW     = BW + 2;

  localparam longint PI_Q30 = 64'sd3373259426;
  localparam longint PI_A   = (PI_Q30 + (64'sd1 <<< (ASHIFT - 1))) >>> ASHIFT;

  localparam int MAG_W = 21 + GUARD_BITS;
  localparam int INVK_W = 30;
  localparam longint unsigned INVK_LIMIT_Q30 = 64'd652032875;
  localparam longint unsigned INVK_CORR_Q30  = 64'd434688583;
  localparam logic [INVK_W-1:0] INVK =
    INVK_W'(INVK_LIMIT_Q30 + (INVK_CORR_Q30 >> (2 * CORDIC_STAGES)));
  localparam int PW = MAG_W + INVK_W;
  localparam int DIST_SHIFT = ACC_FRAC + GUARD_BITS;
  localparam int DIST_W = PW - DIST_SHIFT;

  // Cycles from an accepted start to the result strobe.
  localparam int LATENCY = CORDIC_STAGES + 5;

  localparam logic signed [ZW-1:0] ATAN_Q30 [MAX_TABLE] = '{
    35'sd843314857, 35'sd497837829, 35'sd263043837, 35'sd133525159,
    35'sd67021687,  35'sd33543516,  35'sd16775851,  35'sd8388437,
    35'sd4194283,   35'sd2097149,   35'sd1048576,   35'sd524288,
    35'sd262144,    35'sd131072,    35'sd65536,     35'sd32768,
    35'sd16384,     35'sd8192,      35'sd4096,      35'sd2048,
    35'sd1024,      35'sd512,       35'sd256,       35'sd128
  };

  typedef enum logic [2:0] {
    REG_GOAL_X     = 3'd0,
    REG_GOAL_Y     = 3'd1,
    REG_ARRIVE_RAD = 3'd2,
    REG_MAX_LIN    = 3'd3,
    REG_MAX_TURN   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;
  } sample_t;

  typedef struct packed {
    logic        [16:0] lin_cmd;
    logic signed [15:0] ang_cmd;
    logic               arrived;
  } command_t;

  typedef struct packed {
    logic signed [31:0] goal_x_pos;
    logic signed [31:0] goal_y_pos;
    logic        [16:0] arrive_radius;
    logic        [16:0] max_linear_speed;
    logic        [14:0] max_turn_rate;
  } cfg_t;

  // One beat travelling down the CORDIC chain.
  typedef struct packed {
    logic                 valid;
    logic                 zero;
    logic signed [15:0]   heading;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

endpackage

// File: src/go_to_goal_velocity_command_unit.sv
// Top level of the go-to-goal velocity command unit: configuration registers,
// entry stages, the CORDIC cell chain and the back end. Depends on gtg_pkg,
// gtg_prep, gtg_cordic_cell, gtg_post and the assertion macro header.

// Each odometry sample (pos_x, pos_y in Q16.16 metres, heading in Q3.13
// radians) is taken on a clock edge with start high and busy low, and its
// command appears on result with done high for exactly one cycle. The
// unit is a straight pipeline: a new sample may be started in every
// cycle, and samples overlap freely. Between start and done lie the
// chain of CORDIC cells, one micro-rotation per cell and cycle, plus
// two entry stages (goal offset, half-plane pre-rotation) and the
// three back-end stages (bearing rounding, gain-correction multiply,
// limits). There is no way to hold results off, so the receiver must take
// every done beat as it comes. busy is high only during reset. The goal,
// arrival radius and both speed limits are written through the cfg port,
// which is always ready; they should be written while no sample is in
// flight, since the goal is read at entry and the limits at the exit.
module go_to_goal_velocity_command_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  gtg_pkg::sample_t  sample,
  output logic              done,
  output gtg_pkg::command_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import gtg_pkg::*;

  `include "go_to_goal_velocity_command_unit_macros.svh"

  cfg_t    cfg;
  logic    accept;
  // chain[0] is the output of the entry stages; chain[k+1] leaves cell k.
  cordic_t chain [CORDIC_STAGES+1];

  assign busy      = rst;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Configuration registers. Indexes beyond the last register are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.goal_x_pos       <= '0;
      cfg.goal_y_pos       <= '0;
      cfg.arrive_radius    <= 17'd655;
      cfg.max_linear_speed <= 17'd13107;
      cfg.max_turn_rate    <= 15'd4096;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GOAL_X:     cfg.goal_x_pos       <= cfg_data;
        REG_GOAL_Y:     cfg.goal_y_pos       <= cfg_data;
        REG_ARRIVE_RAD: cfg.arrive_radius    <= cfg_data[16:0];
        REG_MAX_LIN:    cfg.max_linear_speed <= cfg_data[16:0];
        REG_MAX_TURN:   cfg.max_turn_rate    <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // Offset to the goal and rotation into the right half plane.
  gtg_prep u_prep (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .sample (sample),
    .cfg    (cfg),
    .cout   (chain[0])
  );

  // One cell per micro-rotation; each cell is told its own shift.
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
    gtg_cordic_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .stage (STAGE_W'(k)),
      .cin   (chain[k]),
      .cout  (chain[k+1])
    );
  end

  // Bearing, distance, wrap and limits, ending in the result register.
  gtg_post u_post (
    .clk    (clk),
    .rst    (rst),
    .cin    (chain[CORDIC_STAGES]),
    .cfg    (cfg),
    .done   (done),
    .result (result)
  );

  // Every started sample gives exactly one done beat, a fixed time later.
  `GTG_ASSERT_ALWAYS(a_fixed_latency, done == $past(accept, LATENCY), "done out of step with start")
  // On arrival both commands are zero.
  `GTG_ASSERT_IMPLY(a_arrive_zero, done && result.arrived, (result.lin_cmd == '0) && (result.ang_cmd == '0), "arrival with nonzero command")
  // The linear command never exceeds its limit.
  `GTG_ASSERT_IMPLY(a_lin_limit, done, result.lin_cmd <= cfg.max_linear_speed, "linear command over limit")
  // The angular command stays inside the symmetric turn-rate limit.
  `GTG_ASSERT_IMPLY(a_ang_limit, done, ($signed(result.ang_cmd) <= $signed({2'b00, cfg.max_turn_rate})) && ($signed(result.ang_cmd) >= -$signed({2'b00, cfg.max_turn_rate})), "angular command over limit")

endmodule

// File: src/gtg_prep.sv
// Entry stages: goal offset and the pre-rotation into the right half plane.
// Depends on gtg_pkg.
module gtg_prep (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  gtg_pkg::sample_t sample,
  input  gtg_pkg::cfg_t    cfg,
  output gtg_pkg::cordic_t cout
);
  import gtg_pkg::*;

  logic                 v0;
  logic                 zero0;
  logic signed [15:0]   hd0;
  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic signed [DW-1:0] dx_next;
  logic signed [DW-1:0] dy_next;
  logic signed [XW-1:0] x0;
  logic signed [XW-1:0] y0;
  cordic_t              rot;

  assign dx_next = DW'(cfg.goal_x_pos) - DW'(sample.pos_x);
  assign dy_next = DW'(cfg.goal_y_pos) - DW'(sample.pos_y);

  always_ff @(posedge clk) begin
    dx    <= dx_next;
    dy    <= dy_next;
    hd0   <= sample.heading;
    zero0 <= (dx_next == '0) && (dy_next == '0);
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= accept;
    end
  end

  assign x0 = {{(XW-DW-GUARD_BITS){dx[DW-1]}}, dx, {GUARD_BITS{1'b0}}};
  assign y0 = {{(XW-DW-GUARD_BITS){dy[DW-1]}}, dy, {GUARD_BITS{1'b0}}};

  // A vector in the left half plane is turned by pi before the iterations.
  always_comb begin
    rot.valid   = v0;
    rot.zero    = zero0;
    rot.heading = hd0;
    if (x0[XW-1]) begin
      rot.x = -x0;
      rot.y = -y0;
      rot.z = y0[XW-1] ? -ZW'(PI_Q30) : ZW'(PI_Q30);
    end else begin
      rot.x = x0;
      rot.y = y0;
      rot.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cout <= '0;
    end else begin
      cout <= rot;
    end
  end

endmodule

// File: src/gtg_cordic_cell.sv
// One vectoring micro-rotation of the CORDIC chain, registered.
// Depends on gtg_pkg for the beat type and the arctangent table.
module gtg_cordic_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [gtg_pkg::STAGE_W-1:0]   stage,
  input  gtg_pkg::cordic_t              cin,
  output gtg_pkg::cordic_t              cout
);
  import gtg_pkg::*;

  logic signed [XW-1:0] xv;
  logic signed [XW-1:0] yv;
  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  cordic_t              cell_next;

  assign xv = cin.x;
  assign yv = cin.y;
  assign xs = xv >>> stage;
  assign ys = yv >>> stage;

  // Rotate toward the x axis; the sign of y picks the direction.
  always_comb begin
    cell_next = cin;
    if (!yv[XW-1]) begin
      cell_next.x = xv + ys;
      cell_next.y = yv - xs;
      cell_next.z = cin.z + ATAN_Q30[stage];
    end else begin
      cell_next.x = xv - ys;
      cell_next.y = yv + xs;
      cell_next.z = cin.z - ATAN_Q30[stage];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cout <= '0;
    end else begin
      cout <= cell_next;
    end
  end

endmodule

// File: src/gtg_post.sv
// Back end: bearing rounding, gain correction, angle wrap and limits.
// Depends on gtg_pkg.
module gtg_post (
  input  logic              clk,
  input  logic              rst,
  input  gtg_pkg::cordic_t  cin,
  input  gtg_pkg::cfg_t     cfg,
  output logic              done,
  output gtg_pkg::command_t result
);
  import gtg_pkg::*;

  // Stage A: bearing and saturated magnitude.
  logic                    va;
  logic signed [BW-1:0]    bearing;
  logic signed [15:0]      hda;
  logic        [MAG_W-1:0] mag;
  logic signed [ZW-1:0]    zr;
  logic        [MAG_W-1:0] mag_next;

  // Stage B: product and wrapped angle error.
  logic                    vb;
  logic        [PW-1:0]    prod;
  logic signed [EW-1:0]    errw;
  logic signed [EW-1:0]    err0;
  logic signed [EW-1:0]    err1;
  logic signed [EW-1:0]    err2;

  // Stage C: rounding, arrival test and limits.
  logic        [DIST_W-1:0] distance;
  logic signed [EW-1:0]     mt;
  logic signed [EW-1:0]     ang;
  command_t                 result_next;

  assign zr = cin.z + ZW'(64'sd1 <<< (ASHIFT - 1));

  always_comb begin
    if (cin.x[XW-1]) begin
      mag_next = '0;
    end else if (cin.x > XW'(64'sd1 <<< (MAG_W - 1))) begin
      mag_next = MAG_W'(64'd1 << (MAG_W - 1));
    end else begin
      mag_next = cin.x[MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    bearing <= cin.zero ? '0 : BW'(zr >>> ASHIFT);
    hda     <= cin.heading;
    mag     <= mag_next;
    if (rst) begin
      va <= 1'b0;
    end else begin
      va <= cin.valid;
    end
  end

  // Two correction steps cover every heading code and every bearing.
  always_comb begin
    err0 = EW'(bearing) - EW'(hda);
    if (err0 > EW'(PI_A)) begin
      err1 = err0 - EW'(2 * PI_A);
    end else if (err0 < -EW'(PI_A)) begin
      err1 = err0 + EW'(2 * PI_A);
    end else begin
      err1 = err0;
    end
    if (err1 > EW'(PI_A)) begin
      err2 = err1 - EW'(2 * PI_A);
    end else if (err1 < -EW'(PI_A)) begin
      err2 = err1 + EW'(2 * PI_A);
    end else begin
      err2 = err1;
    end
  end

  always_ff @(posedge clk) begin
    prod <= PW'(mag) * PW'(INVK);
    errw <= err2;
    if (rst) begin
      vb <= 1'b0;
    end else begin
      vb <= va;
    end
  end

  assign distance = prod[PW-1:DIST_SHIFT] + DIST_W'(prod[DIST_SHIFT-1]);
  assign mt       = EW'({1'b0, cfg.max_turn_rate});

  always_comb begin
    if (errw > mt) begin
      ang = mt;
    end else if (errw < -mt) begin
      ang = -mt;
    end else begin
      ang = errw;
    end
    if (distance < DIST_W'(cfg.arrive_radius)) begin
      result_next.lin_cmd = '0;
      result_next.ang_cmd = '0;
      result_next.arrived = 1'b1;
    end else begin
      result_next.lin_cmd = (distance > DIST_W'(cfg.max_linear_speed)) ?
                            cfg.max_linear_speed : distance[16:0];
      result_next.ang_cmd = ang[15:0];
      result_next.arrived = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vb;
    end
  end

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the go-to-goal velocity command unit.
// Depends on gtg_pkg for the port types and register names, and on the RTL top.
// The command for each odometry beat is predicted in the bench and checked.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gtg_pkg::*;

  // Fixed-point constants of the controller. The bearing is accumulated with
  // 30 fraction bits and then rounded to the angle format. The offsets carry
  // 8 guard bits through the rotations.
  localparam int     ROT_STEPS    = CORDIC_STAGES;
  localparam int     Z_TO_ANGLE   = 30 - ANGLE_FRAC_BITS;
  localparam int     GUARD_SHIFT  = 8;
  localparam int     GAIN_SHIFT   = 30 + GUARD_SHIFT;
  localparam longint PI_RAD_Q30   = 64'sd3373259426;
  localparam longint MAG_CLAMP    = 64'sd1 <<< (20 + GUARD_SHIFT);
  localparam longint unsigned INV_GAIN_BASE = 64'd652032875;
  localparam longint unsigned INV_GAIN_TAIL = 64'd434688583;
  localparam longint ARCTAN_Q30 [24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687,
    33543516, 16775851, 8388437, 4194283, 2097149,
    1048576, 524288, 262144, 131072, 65536,
    32768, 16384, 8192, 4096, 2048,
    1024, 512, 256, 128
  };

  // Register indexes above the last real register must be ignored.
  localparam logic [2:0] FIRST_SPARE_REG = 3'(REG_MAX_TURN) + 3'd1;

  // The watchdog ends the run after this many cycles without any progress.
  localparam int STALL_LIMIT = 4000;

  logic     clk;
  logic     rst       = 1'b1;
  logic     start     = 1'b0;
  logic     busy;
  sample_t  sample    = '0;
  logic     done;
  command_t result;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data  = '0;

  // Register contents as the bench believes them, and the commands that are
  // owed by the unit, oldest first.
  cfg_t     cfg_shadow;
  command_t pending_commands [$];
  int       mismatch_count = 0;
  int       quiet_cycles   = 0;

  go_to_goal_velocity_command_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .sample    (sample),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Round half up while shifting right by sh bits.
  function automatic longint round_half_up(input longint v, input int sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  // Computes the command that one odometry sample should produce under the
  // given register settings.
  function automatic command_t predict_command(input sample_t s, input cfg_t c);
    longint dx, dy, x, y, z, xs, ys;
    longint bearing, err, mag, distance, pi_a;
    longint unsigned inv_gain, lin;
    command_t cmd;
    dx = longint'($signed(c.goal_x_pos)) - longint'($signed(s.pos_x));
    dy = longint'($signed(c.goal_y_pos)) - longint'($signed(s.pos_y));
    pi_a = round_half_up(PI_RAD_Q30, Z_TO_ANGLE);
    x = dx <<< GUARD_SHIFT;
    y = dy <<< GUARD_SHIFT;
    z = 0;
    // Left half plane: rotate by pi first so the vectoring pass converges.
    if (x < 0) begin
      z = (y >= 0) ? PI_RAD_Q30 : -PI_RAD_Q30;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < ROT_STEPS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ARCTAN_Q30[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ARCTAN_Q30[i];
      end
    end
    // With no offset at all the bearing is defined as zero.
    bearing = (dx == 0 && dy == 0) ? 0 : round_half_up(z, Z_TO_ANGLE);

    // Gain correction on a saturated magnitude.
    mag = x;
    if (mag > MAG_CLAMP) mag = MAG_CLAMP;
    if (mag < 0) mag = 0;
    inv_gain = INV_GAIN_BASE + (INV_GAIN_TAIL >> (2 * ROT_STEPS));
    distance = longint'((longint'(unsigned'(mag)) * inv_gain +
                         (64'd1 << (GAIN_SHIFT - 1))) >> GAIN_SHIFT);

    cmd = '0;
    if (distance < longint'(c.arrive_radius)) begin
      cmd.arrived = 1'b1;
      return cmd;
    end

    lin = longint'(unsigned'(distance));
    if (lin > longint'(c.max_linear_speed)) lin = c.max_linear_speed;

    // Heading error wrapped into plus or minus pi, then limited.
    err = bearing - longint'($signed(s.heading));
    while (err > pi_a) err = err - 2 * pi_a;
    while (err < -pi_a) err = err + 2 * pi_a;
    if (err > longint'(c.max_turn_rate)) err = c.max_turn_rate;
    if (err < -longint'(c.max_turn_rate)) err = -longint'(c.max_turn_rate);
    if (err > 32767) err = 32767;
    if (err < -32768) err = -32768;

    cmd.lin_cmd = lin[16:0];
    cmd.ang_cmd = err[15:0];
    return cmd;
  endfunction

  // Scoreboard. Command beats are checked before new samples are queued, so
  // the order within one edge is fixed. Register writes are mirrored after
  // the prediction of the same edge, as the unit would see them.
  always @(posedge clk) begin : scoreboard
    command_t want;
    if (rst) begin
      cfg_shadow.goal_x_pos       = '0;
      cfg_shadow.goal_y_pos       = '0;
      cfg_shadow.arrive_radius    = 17'd655;
      cfg_shadow.max_linear_speed = 17'd13107;
      cfg_shadow.max_turn_rate    = 15'd4096;
      pending_commands.delete();
    end else begin
      if (done === 1'b1) begin
        if (pending_commands.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Unexpected command beat: lin %0d ang %0d arrived %0b",
                     result.lin_cmd, $signed(result.ang_cmd), result.arrived);
        end else begin
          want = pending_commands.pop_front();
          if (result.lin_cmd !== want.lin_cmd || result.ang_cmd !== want.ang_cmd ||
              result.arrived !== want.arrived) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("Command mismatch: expected lin %0d ang %0d arrived %0b, got lin %0d ang %0d arrived %0b",
                       want.lin_cmd, $signed(want.ang_cmd), want.arrived,
                       result.lin_cmd, $signed(result.ang_cmd), result.arrived);
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0)
        pending_commands.push_back(predict_command(sample, cfg_shadow));
      if (cfg_valid === 1'b1 && cfg_ready === 1'b1) begin
        case (cfg_reg_t'(cfg_index))
          REG_GOAL_X:     cfg_shadow.goal_x_pos       = cfg_data;
          REG_GOAL_Y:     cfg_shadow.goal_y_pos       = cfg_data;
          REG_ARRIVE_RAD: cfg_shadow.arrive_radius    = cfg_data[16:0];
          REG_MAX_LIN:    cfg_shadow.max_linear_speed = cfg_data[16:0];
          REG_MAX_TURN:   cfg_shadow.max_turn_rate    = cfg_data[14:0];
          default: ;
        endcase
      end
    end
  end

  // Watchdog: any accepted sample, command beat or register write counts as
  // progress. A long silence means the unit has hung.
  always @(posedge clk) begin
    if (rst || (start === 1'b1 && busy === 1'b0) || done === 1'b1 ||
        (cfg_valid === 1'b1 && cfg_ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Presents one sample and returns at the edge that accepts it. start stays
  // high so that back-to-back calls give one beat per cycle.
  task automatic send_sample(input sample_t s);
    start  <= 1'b1;
    sample <= s;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Sender gap of length n; nothing is driven when n is zero.
  task automatic pause_sender(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Stops sending and waits until every owed command has come back. Since
  // every sample gives exactly one command, the pipeline is then empty.
  task automatic wait_for_drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_commands.size() != 0);
  endtask

  // One register write; cfg_valid is left high for the next write.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
  endtask

  // Loads all five registers once the unit is idle. A write to a spare
  // index comes last, so a decoding fault there would spoil the settings.
  task automatic apply_cfg(input cfg_t c);
    wait_for_drain();
    write_reg(REG_GOAL_X, c.goal_x_pos);
    write_reg(REG_GOAL_Y, c.goal_y_pos);
    write_reg(REG_ARRIVE_RAD, 32'(c.arrive_radius));
    write_reg(REG_MAX_LIN, 32'(c.max_linear_speed));
    write_reg(REG_MAX_TURN, 32'(c.max_turn_rate));
    write_reg(3'(FIRST_SPARE_REG + $urandom_range(0, 2)), $urandom);
    cfg_valid <= 1'b0;
  endtask

  // Sends a sample that sits at offset (dx, dy) short of the goal.
  task automatic send_offset(input cfg_t c, input int dx, input int dy,
                             input logic [15:0] hdg);
    sample_t s;
    s.pos_x   = c.goal_x_pos - 32'(dx);
    s.pos_y   = c.goal_y_pos - 32'(dy);
    s.heading = hdg;
    send_sample(s);
  endtask

  function automatic logic [15:0] random_heading();
    if ($urandom_range(0, 7) == 0) return 16'($urandom);
    return 16'(int'($urandom_range(0, 51472)) - 25736);
  endfunction

  // Some samples land near the goal, where arrival and an unsaturated linear
  // command occur; the rest reach out to large and fully random offsets.
  function automatic sample_t random_sample(input cfg_t c);
    sample_t s;
    int kind;
    int dx, dy;
    kind = $urandom_range(0, 9);
    dx = 0;
    dy = 0;
    case (kind)
      0: begin
        dx = int'($urandom_range(0, 2048)) - 1024;
        dy = int'($urandom_range(0, 2048)) - 1024;
      end
      1, 2, 3: begin
        dx = int'($urandom_range(0, 262144)) - 131072;
        dy = int'($urandom_range(0, 262144)) - 131072;
      end
      4, 5, 6: begin
        dx = int'($urandom_range(0, 33554432)) - 16777216;
        dy = int'($urandom_range(0, 33554432)) - 16777216;
      end
      9: begin
        case ($urandom_range(0, 2))
          0: dx = int'($urandom_range(0, 2097152)) - 1048576;
          1: dy = int'($urandom_range(0, 2097152)) - 1048576;
          default: ;
        endcase
      end
      default: ;
    endcase
    if (kind == 7 || kind == 8) begin
      s.pos_x = $urandom;
      s.pos_y = $urandom;
    end else begin
      s.pos_x = c.goal_x_pos - 32'(dx);
      s.pos_y = c.goal_y_pos - 32'(dy);
    end
    s.heading = random_heading();
    return s;
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    if ($urandom_range(0, 1) == 0) begin
      c.goal_x_pos = $urandom;
      c.goal_y_pos = $urandom;
    end else begin
      c.goal_x_pos = 32'(int'($urandom_range(0, 2097152)) - 1048576);
      c.goal_y_pos = 32'(int'($urandom_range(0, 2097152)) - 1048576);
    end
    c.arrive_radius    = ($urandom_range(0, 1) == 0) ? 17'($urandom_range(0, 2000))
                                                     : 17'($urandom_range(0, 65536));
    c.max_linear_speed = 17'($urandom_range(0, 65536));
    c.max_turn_rate    = 15'($urandom_range(0, 25736));
    return c;
  endfunction

  // The register values after reset: one sample arrives, one well inside
  // the default radius, and one far off so both default limits apply.
  task automatic test_reset_config();
    send_offset(cfg_shadow, 0, 0, 16'sd0);
    send_offset(cfg_shadow, 100, 0, 16'sd300);
    send_offset(cfg_shadow, -65536, 0, 16'sd0);
  endtask

  // Directed corners: all eight directions under mixed and extreme headings,
  // the arrival boundary, zero offset, and offsets that saturate the magnitude.
  task automatic test_directed_cases();
    cfg_t c;
    int   dir_x [8] = '{40000, 40000, 0, -40000, -40000, -40000, 0, 40000};
    int   dir_y [8] = '{0, 40000, 40000, 40000, 0, -40000, -40000, -40000};
    logic [15:0] hdg [8] = '{16'sd0, 16'sd25736, -16'sd25736, 16'sh7FFF,
                             16'sh8000, 16'sd12000, -16'sd12000, 16'sd100};
    sample_t s;
    c.goal_x_pos       = 32'sd1000;
    c.goal_y_pos       = -32'sd2000;
    c.arrive_radius    = 17'd655;
    c.max_linear_speed = 17'd65536;
    c.max_turn_rate    = 15'd25736;
    apply_cfg(c);
    for (int i = 0; i < 8; i++) send_offset(c, dir_x[i], dir_y[i], hdg[i]);
    send_offset(c, 0, 0, 16'sd0);
    send_offset(c, 3, -2, 16'sd5);
    for (int d = 654; d <= 656; d++) send_offset(c, d, 0, 16'sd0);
    s.pos_x = 32'sh8000_0000;
    s.pos_y = 32'sh7FFF_FFFF;
    s.heading = 16'sh8000;
    send_sample(s);
    s.pos_x = 32'sh7FFF_FFFF;
    s.pos_y = 32'sh8000_0000;
    s.heading = 16'sh7FFF;
    send_sample(s);

    // Goal at the corners of the position range with no arrival radius: a
    // sample exactly on the goal is not arrived and its bearing is zero.
    c.goal_x_pos       = 32'sh7FFF_FFFF;
    c.goal_y_pos       = 32'sh8000_0000;
    c.arrive_radius    = 17'd0;
    apply_cfg(c);
    send_offset(c, 0, 0, 16'sd20000);
    send_offset(c, 0, 0, 16'sh8000);
    s.pos_x = 32'sh8000_0000;
    s.pos_y = 32'sh7FFF_FFFF;
    s.heading = 16'sd0;
    send_sample(s);
  endtask

  // Random traffic in bursts over several register settings. The first
  // settings are the extremes: widest limits, all-zero limits, and values
  // that fill the register widths.
  task automatic test_random_traffic();
    cfg_t c;
    int   sent;
    int   burst;
    int   gap;
    for (int phase = 0; phase < 8; phase++) begin
      c = random_cfg();
      case (phase)
        0: begin
          c.goal_x_pos       = 32'sh7FFF_FFFF;
          c.goal_y_pos       = 32'sh8000_0000;
          c.arrive_radius    = 17'd65536;
          c.max_linear_speed = 17'd65536;
          c.max_turn_rate    = 15'd25736;
        end
        1: begin
          c.goal_x_pos       = 32'sh8000_0000;
          c.goal_y_pos       = 32'sh7FFF_FFFF;
          c.arrive_radius    = 17'd0;
          c.max_linear_speed = 17'd0;
          c.max_turn_rate    = 15'd0;
        end
        2: begin
          c.arrive_radius    = 17'h1FFFF;
          c.max_linear_speed = 17'h1FFFF;
          c.max_turn_rate    = 15'h7FFF;
        end
        default: ;
      endcase
      apply_cfg(c);
      sent = 0;
      while (sent < 200) begin
        burst = $urandom_range(1, 40);
        for (int k = 0; k < burst && sent < 200; k++) begin
          send_sample(random_sample(c));
          sent++;
        end
        // Gaps of random length, with a share of back-to-back bursts and
        // the odd full drain of the pipeline.
        gap = $urandom_range(0, 9);
        if (gap == 9 && $urandom_range(0, 3) == 0) wait_for_drain();
        else if (gap >= 4) pause_sender($urandom_range(1, 30));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_config();
    test_directed_cases();
    test_random_traffic();
    wait_for_drain();
    // Any stray command beat after the last one owed is caught here.
    repeat (LATENCY + 4) @(posedge clk);
    if (mismatch_count == 0 && pending_commands.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
